@@ hdl/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg: shared definitions for the running standard deviation unit
// Constants, iteration counts and the control, status and result types that
// pass between the top level and the statistics core.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int COUNT_LIMIT  = 65535;
  localparam int SAMPLE_WIDTH = 16;

  localparam int IN_WIDTH    = 16;
  localparam int MEAN_WIDTH  = 24;
  localparam int DEV_WIDTH   = 24;
  localparam int COUNT_WIDTH = 16;
  localparam int SUM_WIDTH   = 32;
  localparam int SQ_WIDTH    = 48;

  localparam int MEAN_STEPS = 39;
  localparam int DEV_STEPS  = 48;
  localparam int SQRT_STEPS = 24;

  typedef struct packed {
    logic start;
    logic ack;
  } ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } status_t;

  typedef struct packed {
    logic                   saturated;
    logic [COUNT_WIDTH-1:0] samples_seen;
    logic [DEV_WIDTH-1:0]   deviation_q8;
    logic [MEAN_WIDTH-1:0]  mean_q8;
  } result_t;

endpackage

@@ hdl/rsd_core.sv @@
// ----------------------------------------------------------------------------
// rsd_core: accumulators and iterative statistics sequencer
// Holds count, sum and sum of squares, and derives the mean and deviation
// with one shared multiplier and one shared compare-subtract unit.
// ----------------------------------------------------------------------------
module rsd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  rsd_pkg::ctrl_t                 ctrl,
  input  logic [rsd_pkg::IN_WIDTH-1:0]   sample,
  output rsd_pkg::status_t               status,
  output rsd_pkg::result_t               result
);
  import rsd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_M1   = 4'd3;
  localparam logic [3:0] S_M2   = 4'd4;
  localparam logic [3:0] S_M3   = 4'd5;
  localparam logic [3:0] S_M4   = 4'd6;
  localparam logic [3:0] S_N2   = 4'd7;
  localparam logic [3:0] S_DIVM = 4'd8;
  localparam logic [3:0] S_DIVD = 4'd9;
  localparam logic [3:0] S_SQRT = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                  state;
  logic [5:0]                  iter;
  logic signed [IN_WIDTH-1:0]  xs;
  logic                        drop;
  logic [COUNT_WIDTH-1:0]      count;
  logic signed [SUM_WIDTH-1:0] sum;
  logic [SQ_WIDTH-1:0]         sumsq;
  logic [61:0]                 prod;
  logic [61:0]                 s1sq;
  logic [39:0]                 lo;
  logic [61:0]                 d;
  logic [31:0]                 rem;
  logic [47:0]                 dsr;
  logic [47:0]                 quo;
  logic [31:0]                 divisor;
  logic [47:0]                 v;
  logic [47:0]                 root;
  logic [47:0]                 sbit;
  logic [MEAN_WIDTH-1:0]       mean;
  logic [DEV_WIDTH-1:0]        dev;

  logic [IN_WIDTH-1:0]  xbits;
  logic [IN_WIDTH-1:0]  xmag;
  logic [SUM_WIDTH-1:0] sbits;
  logic [30:0]          s1mag;
  logic [30:0]          mul_a;
  logic [30:0]          mul_b;
  logic [61:0]          mul_p;
  logic [32:0]          div_a;
  logic [48:0]          sub_a;
  logic [48:0]          sub_b;
  logic [48:0]          diff;
  logic                 ge;
  logic [31:0]          rem_next;
  logic [47:0]          quo_next;
  logic [47:0]          v_next;
  logic [47:0]          root_next;
  logic [23:0]          mean_mag;

  assign xbits = xs;
  assign xmag  = xs[IN_WIDTH-1] ? (~xbits + 16'd1) : xbits;
  assign sbits = sum;
  assign s1mag = sum[SUM_WIDTH-1] ? 31'(~sbits + 32'd1) : sbits[30:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = 31'(xmag);
        mul_b = 31'(xmag);
      end
      S_M1: begin
        mul_a = s1mag;
        mul_b = s1mag;
      end
      S_M2: begin
        mul_a = 31'(count);
        mul_b = 31'(sumsq[23:0]);
      end
      S_M3: begin
        mul_a = 31'(count);
        mul_b = 31'(sumsq[47:24]);
      end
      S_M4: begin
        mul_a = 31'(count);
        mul_b = 31'(count);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_a = {rem, dsr[47]};

  always_comb begin
    if (state == S_SQRT) begin
      sub_a = {1'b0, v};
      sub_b = {1'b0, root + sbit};
    end else begin
      sub_a = {16'd0, div_a};
      sub_b = {17'd0, divisor};
    end
  end

  assign diff      = sub_a - sub_b;
  assign ge        = ~diff[48];
  assign rem_next  = ge ? diff[31:0] : div_a[31:0];
  assign quo_next  = {quo[46:0], ge};
  assign v_next    = ge ? diff[47:0] : v;
  assign root_next = ge ? ((root >> 1) + sbit) : (root >> 1);

  assign mean_mag = quo_next[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            xs    <= IN_WIDTH'(signed'(sample[SAMPLE_WIDTH-1:0]));
            drop  <= (32'(count) >= 32'(COUNT_LIMIT));
            state <= (32'(count) >= 32'(COUNT_LIMIT)) ? S_M1 : S_SQ;
          end
        end
        S_SQ: begin
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          count <= count + 16'd1;
          sum   <= sum + SUM_WIDTH'(xs);
          sumsq <= sumsq + SQ_WIDTH'(prod[31:0]);
          state <= S_M1;
        end
        S_M1: begin
          prod  <= mul_p;
          state <= S_M2;
        end
        S_M2: begin
          s1sq  <= prod;
          prod  <= mul_p;
          state <= S_M3;
        end
        S_M3: begin
          lo    <= prod[39:0];
          prod  <= mul_p;
          state <= S_M4;
        end
        S_M4: begin
          d     <= 62'(({prod[39:0], 24'd0}) + 64'(lo) - 64'(s1sq));
          prod  <= mul_p;
          state <= S_N2;
        end
        S_N2: begin
          rem     <= '0;
          dsr     <= {s1mag, 17'd0};
          quo     <= '0;
          divisor <= 32'(count);
          iter    <= 6'(MEAN_STEPS - 1);
          state   <= S_DIVM;
        end
        S_DIVM: begin
          if (iter == '0) begin
            mean    <= sum[SUM_WIDTH-1] ? (~mean_mag + 24'd1) : mean_mag;
            rem     <= {2'b00, d[61:32]};
            dsr     <= {d[31:0], 16'd0};
            quo     <= '0;
            divisor <= prod[31:0];
            iter    <= 6'(DEV_STEPS - 1);
            state   <= S_DIVD;
          end else begin
            rem  <= rem_next;
            dsr  <= {dsr[46:0], 1'b0};
            quo  <= quo_next;
            iter <= iter - 6'd1;
          end
        end
        S_DIVD: begin
          if (iter == '0) begin
            v     <= quo_next;
            root  <= '0;
            sbit  <= 48'd1 << 46;
            iter  <= 6'(SQRT_STEPS - 1);
            state <= S_SQRT;
          end else begin
            rem  <= rem_next;
            dsr  <= {dsr[46:0], 1'b0};
            quo  <= quo_next;
            iter <= iter - 6'd1;
          end
        end
        S_SQRT: begin
          v    <= v_next;
          root <= root_next;
          sbit <= sbit >> 2;
          if (iter == '0) begin
            dev   <= root_next[DEV_WIDTH-1:0];
            state <= S_DONE;
          end else begin
            iter <= iter - 6'd1;
          end
        end
        S_DONE: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status.idle = (state == S_IDLE);
  assign status.done = (state == S_DONE);

  assign result.mean_q8      = mean;
  assign result.deviation_q8 = dev;
  assign result.samples_seen = count;
  assign result.saturated    = drop;

endmodule

@@ hdl/running_standard_deviation_unit.sv @@
// ----------------------------------------------------------------------------
// running_standard_deviation_unit: running mean and population deviation
// A sample that arrives at the count limit is not added but still gets a
// result word. A new sample word is taken only while the core is idle, after
// the shared divider (39 and 48 steps) and the 24-step square root, which run
// one after the other, are through with the last one.
// A result word waits in the output register while the next sample is taken.
// Synchronous reset clears the count, the sum and the sum of squares.
// ----------------------------------------------------------------------------
module running_standard_deviation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // mean_q8, deviation_q8, samples_seen
  output logic        m_tuser    // saturated
);
  import rsd_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  result_t result;

  assign s_tready   = status.idle;
  assign ctrl.start = s_tvalid & status.idle;
  assign ctrl.ack   = status.done & (~m_tvalid | m_tready);

  rsd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .sample (s_tdata),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ack) begin
      m_tdata <= {result.samples_seen, result.deviation_q8, result.mean_q8};
      m_tuser <= result.saturated;
    end
  end

endmodule
